>>> src/brb_pkg.sv
// shared types and constants of the byte ring buffer
package brb_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int MAX_RUN_DEF     = 64;
    localparam int SIZE_LIMIT      = 256;
    localparam int BYTE_W          = 8;
    localparam int COUNT_W         = 7;
    localparam int LEVEL_W         = 8;
    localparam int SIZE_W          = 9;
    localparam int OP_W            = 2;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_DROP  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                operation;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] item_count;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last_result;
        logic               write_accepted;
        logic [COUNT_W-1:0] moved_count;
        logic [LEVEL_W-1:0] used_count;
        logic [LEVEL_W-1:0] free_count;
    } result_t;

endpackage

>>> src/brb_if.sv
// handshake channels of the byte ring buffer
interface brb_item_if;
    logic           valid;
    logic           ready;
    brb_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface brb_result_if;
    logic             valid;
    logic             ready;
    brb_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface brb_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [brb_pkg::SIZE_W-1:0]  ring_size;

    modport source (output valid, output ring_size, input ready);
    modport sink (input valid, input ring_size, output ready);
endinterface

>>> src/byte_ring_buffer.sv
// byte ring buffer top level: fifo control around one byte store
// A byte FIFO in a circular store of ring_size slots (2 to 256, reset 256), one slot kept
// empty, so ring_size-1 bytes fit. Each item writes one byte, reads or peeks up to
// item_count bytes (capped at MAX_RUN) as one result beat per byte, or drops bytes. One
// item is worked on at a time. A write, a drop and an empty read or peek pass from
// acceptance through ST_RESULT to a registered result beat. A read or peek of n bytes
// runs in ST_STREAM: the store has one registered read port, and after the first access it
// streams one byte per cycle while the result side keeps taking beats. Writing ring_size
// empties the buffer. No clearing pass is needed after reset.
module byte_ring_buffer #(
    parameter int STORE_DEPTH = brb_pkg::STORE_DEPTH_DEF,
    parameter int MAX_RUN     = brb_pkg::MAX_RUN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    brb_item_if.sink            items,
    brb_result_if.source        results,
    brb_cfg_if.sink             cfg
);

    localparam int SIZE_TOP = (STORE_DEPTH < brb_pkg::SIZE_LIMIT) ?
                              STORE_DEPTH : brb_pkg::SIZE_LIMIT;
    localparam int AW = $clog2(SIZE_TOP);
    localparam logic [brb_pkg::SIZE_W-1:0]  SIZE_TOP_V = brb_pkg::SIZE_W'(SIZE_TOP);
    localparam logic [brb_pkg::COUNT_W-1:0] RUN_CAP    = brb_pkg::COUNT_W'(MAX_RUN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESULT,
        ST_STREAM
    } state_t;

    state_t                         state_reg, state_next;
    logic [brb_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [AW-1:0]                  tail_reg, tail_next;
    logic [AW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [brb_pkg::LEVEL_W-1:0]    used_reg, used_next;
    logic                           is_read_reg, is_read_next;
    logic                           acc_reg, acc_next;
    logic [brb_pkg::COUNT_W-1:0]    moved_reg, moved_next;
    logic [brb_pkg::COUNT_W-1:0]    issue_left_reg, issue_left_next;
    logic [brb_pkg::COUNT_W-1:0]    emit_left_reg, emit_left_next;
    logic                           rd_pending_reg, rd_pending_next;
    brb_pkg::result_t               out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    logic                           item_fire;
    logic                           cfg_fire;
    logic                           can_load;
    logic                           write_ok;
    logic                           load;
    logic                           issue;
    logic [brb_pkg::COUNT_W-1:0]    req_cap;
    logic [brb_pkg::COUNT_W-1:0]    n_take;
    logic [brb_pkg::SIZE_W-1:0]     free_now;
    logic [brb_pkg::LEVEL_W-1:0]    remain;
    logic [brb_pkg::LEVEL_W-1:0]    used_after;
    logic [brb_pkg::SIZE_W:0]       drop_tail;

    logic                           mem_we;
    logic                           mem_re;
    logic [brb_pkg::BYTE_W-1:0]     mem_rdata;

    function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] idx,
                                               input logic [brb_pkg::SIZE_W-1:0] size);
        logic [brb_pkg::SIZE_W-1:0] inc;
        inc = brb_pkg::SIZE_W'(idx) + 9'd1;
        return (inc == size) ? '0 : inc[AW-1:0];
    endfunction

    function automatic logic [brb_pkg::SIZE_W-1:0] clamp_size(
        input logic [brb_pkg::SIZE_W-1:0] v);
        logic [brb_pkg::SIZE_W-1:0] s;
        s = v;
        if (s < brb_pkg::SIZE_MIN)
        begin
            s = brb_pkg::SIZE_MIN;
        end
        if (s > SIZE_TOP_V)
        begin
            s = SIZE_TOP_V;
        end
        return s;
    endfunction

    brb_ram #(
        .WIDTH (brb_pkg::BYTE_W),
        .DEPTH (SIZE_TOP)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (head_reg),
        .wdata (items.payload.data_byte),
        .re    (mem_re),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    assign items.ready   = (state_reg == ST_IDLE);
    assign cfg.ready     = (state_reg == ST_IDLE);
    assign results.valid = out_valid_reg;
    assign results.payload = out_reg;

    assign item_fire = items.valid && items.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign can_load  = !out_valid_reg || results.ready;

    assign req_cap  = (items.payload.item_count > RUN_CAP) ? RUN_CAP : items.payload.item_count;
    assign n_take   = ({1'b0, req_cap} < used_reg) ? req_cap : used_reg[brb_pkg::COUNT_W-1:0];
    assign free_now = size_reg - 9'd1 - brb_pkg::SIZE_W'(used_reg);
    assign write_ok = (free_now != '0);

    // tail after a drop, from head and what stays
    assign remain    = used_reg - brb_pkg::LEVEL_W'(n_take);
    assign drop_tail = (brb_pkg::SIZE_W'(head_reg) >= brb_pkg::SIZE_W'(remain)) ?
                       (10'(head_reg) - 10'(remain)) :
                       (10'(head_reg) + 10'(size_reg) - 10'(remain));

    assign load  = (state_reg == ST_STREAM) && rd_pending_reg && can_load;
    assign issue = (state_reg == ST_STREAM) && (issue_left_reg != '0) &&
                   (!rd_pending_reg || can_load);
    assign used_after = is_read_reg ? (used_reg - 8'd1) : used_reg;

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        rd_idx_next     = rd_idx_reg;
        used_next       = used_reg;
        is_read_next    = is_read_reg;
        acc_next        = acc_reg;
        moved_next      = moved_reg;
        issue_left_next = issue_left_reg;
        emit_left_next  = emit_left_reg;
        rd_pending_next = rd_pending_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    case (items.payload.operation)
                        brb_pkg::OP_WRITE:
                        begin
                            acc_next   = write_ok;
                            moved_next = brb_pkg::COUNT_W'(write_ok);
                            if (write_ok)
                            begin
                                mem_we    = 1'b1;
                                head_next = step_idx(head_reg, size_reg);
                                used_next = used_reg + 8'd1;
                            end
                            state_next = ST_RESULT;
                        end
                        brb_pkg::OP_DROP:
                        begin
                            acc_next   = 1'b0;
                            moved_next = n_take;
                            tail_next  = drop_tail[AW-1:0];
                            used_next  = remain;
                            state_next = ST_RESULT;
                        end
                        default:
                        begin
                            acc_next     = 1'b0;
                            moved_next   = n_take;
                            is_read_next = (items.payload.operation == brb_pkg::OP_READ);
                            if (n_take == '0)
                            begin
                                state_next = ST_RESULT;
                            end
                            else
                            begin
                                issue_left_next = n_take;
                                emit_left_next  = n_take;
                                rd_idx_next     = tail_reg;
                                state_next      = ST_STREAM;
                            end
                        end
                    endcase
                end
                if (cfg_fire)
                begin
                    size_next = clamp_size(cfg.ring_size);
                    head_next = '0;
                    tail_next = '0;
                    used_next = '0;
                end
            end
            ST_RESULT:
            begin
                if (can_load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.out_byte       = '0;
                    out_next.byte_valid     = 1'b0;
                    out_next.last_result    = 1'b1;
                    out_next.write_accepted = acc_reg;
                    out_next.moved_count    = moved_reg;
                    out_next.used_count     = used_reg;
                    out_next.free_count     = free_now[brb_pkg::LEVEL_W-1:0];
                    state_next              = ST_IDLE;
                end
            end
            ST_STREAM:
            begin
                if (issue)
                begin
                    mem_re          = 1'b1;
                    rd_idx_next     = step_idx(rd_idx_reg, size_reg);
                    issue_left_next = issue_left_reg - 7'd1;
                end
                rd_pending_next = issue || (rd_pending_reg && !load);
                if (load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.out_byte       = mem_rdata;
                    out_next.byte_valid     = 1'b1;
                    out_next.last_result    = (emit_left_reg == 7'd1);
                    out_next.write_accepted = 1'b0;
                    out_next.moved_count    = moved_reg;
                    out_next.used_count     = used_after;
                    out_next.free_count     = brb_pkg::LEVEL_W'(size_reg - 9'd1 -
                                                              brb_pkg::SIZE_W'(used_after));
                    used_next               = used_after;
                    emit_left_next          = emit_left_reg - 7'd1;
                    if (emit_left_reg == 7'd1)
                    begin
                        if (is_read_reg)
                        begin
                            tail_next = rd_idx_reg;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            size_reg       <= clamp_size(brb_pkg::SIZE_RESET);
            head_reg       <= '0;
            tail_reg       <= '0;
            rd_idx_reg     <= '0;
            used_reg       <= '0;
            is_read_reg    <= 1'b0;
            acc_reg        <= 1'b0;
            moved_reg      <= '0;
            issue_left_reg <= '0;
            emit_left_reg  <= '0;
            rd_pending_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            rd_idx_reg     <= rd_idx_next;
            used_reg       <= used_next;
            is_read_reg    <= is_read_next;
            acc_reg        <= acc_next;
            moved_reg      <= moved_next;
            issue_left_reg <= issue_left_next;
            emit_left_reg  <= emit_left_next;
            rd_pending_reg <= rd_pending_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_used_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        brb_pkg::SIZE_W'(used_reg) < size_reg)
        else $error("fill level reached ring size");

    a_idx_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        (brb_pkg::SIZE_W'(head_reg) < size_reg) && (brb_pkg::SIZE_W'(tail_reg) < size_reg))
        else $error("ring index beyond ring size");

    a_pending_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pending_reg |-> (state_reg == ST_STREAM))
        else $error("store read outstanding outside a stream");

    a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && !cfg_fire && write_ok &&
         (items.payload.operation == brb_pkg::OP_WRITE))
        |=> (used_reg == $past(used_reg) + 8'd1))
        else $error("stored byte not counted");

    a_last_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (emit_left_reg == 7'd1)) |=> (state_reg == ST_IDLE) && !rd_pending_reg)
        else $error("stream did not end after last beat");

endmodule

>>> src/brb_ram.sv
// generic single-port-write, registered-read ram
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
